[design/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// h2r_pkg: shared types and constants of the hsv to rgb444 converter
// region codes, stage payload types and the fixed colour arithmetic constants
// ----------------------------------------------------------------------------
`default_nettype none

package h2r_pkg;

	localparam int ChanW      = 8;   // width of hue, saturation and brightness
	localparam int OutW       = 4;   // width of each output channel
	localparam int RegionSteps = 43; // hue steps in one colour region
	localparam int RemScale   = 6;   // scale of the remainder inside a region
	localparam int NumRegions = 6;
	localparam logic [ChanW-1:0] Full = 8'd255;

	// colour region of the hue wheel
	typedef enum logic [2:0] {
		RGN_RED = 3'd0,
		RGN_YEL = 3'd1,
		RGN_GRN = 3'd2,
		RGN_CYN = 3'd3,
		RGN_BLU = 3'd4,
		RGN_MAG = 3'd5
	} region_t;

	// handshake control handed to each stage
	typedef struct packed {
		logic valid;   // beat offered by the stage before
		logic advance; // stage may load this cycle
	} stage_ctl_t;

	// after the region split
	typedef struct packed {
		region_t          region;
		logic [ChanW-1:0] rem;
		logic [ChanW-1:0] sat;
		logic [ChanW-1:0] nsat;
		logic [ChanW-1:0] val;
		logic             grey;
	} split_t;

	// after the first products
	typedef struct packed {
		region_t          region;
		logic [ChanW-1:0] sr;   // (s * rem) >> 8
		logic [ChanW-1:0] sri;  // (s * (255 - rem)) >> 8
		logic [ChanW-1:0] p;
		logic [ChanW-1:0] val;
		logic             grey;
	} prod_t;

	typedef struct packed {
		logic [OutW-1:0] red;
		logic [OutW-1:0] green;
		logic [OutW-1:0] blue;
	} rgb_t;

endpackage

`default_nettype wire

[design/h2r_hsv_if.sv]
// ----------------------------------------------------------------------------
// h2r_hsv_if: hsv input channel
// valid/ready channel carrying one hue, saturation and brightness triple
// ----------------------------------------------------------------------------
`default_nettype none

interface h2r_hsv_if
	import h2r_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [ChanW-1:0] hue;
	logic [ChanW-1:0] saturation;
	logic [ChanW-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

`default_nettype wire

[design/h2r_rgb_if.sv]
// ----------------------------------------------------------------------------
// h2r_rgb_if: rgb444 output channel
// valid/ready channel carrying one 12-bit colour
// ----------------------------------------------------------------------------
`default_nettype none

interface h2r_rgb_if
	import h2r_pkg::*;
;
	logic            valid;
	logic            ready;
	logic [OutW-1:0] red;
	logic [OutW-1:0] green;
	logic [OutW-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

[design/h2r_split.sv]
// ----------------------------------------------------------------------------
// h2r_split: first stage, hue region and scaled remainder
// compares the hue against the region boundaries and forms 255 - s
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_split
	import h2r_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire stage_ctl_t  ctl,
	input  wire  [ChanW-1:0] hue,
	input  wire  [ChanW-1:0] saturation,
	input  wire  [ChanW-1:0] brightness,
	output logic             valid_s1,
	output split_t           data_s1
);

	logic [2:0]       cnt;
	logic [ChanW-1:0] base;
	logic [5:0]       rem_raw;
	split_t           nxt;

	// region boundaries are constants, so these are independent compares
	always_comb begin
		cnt  = 3'd0;
		base = '0;
		for (int i = 1; i < NumRegions; i++) begin
			if (hue >= ChanW'(i * RegionSteps)) begin
				cnt  = cnt + 3'd1;
				base = ChanW'(i * RegionSteps);
			end
		end
		rem_raw     = 6'(hue - base);
		nxt.region  = region_t'(cnt);
		nxt.rem     = ChanW'(rem_raw * RemScale);
		nxt.sat     = saturation;
		nxt.nsat    = Full - saturation;
		nxt.val     = brightness;
		nxt.grey    = (saturation == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.advance) begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance && ctl.valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

[design/h2r_prod.sv]
// ----------------------------------------------------------------------------
// h2r_prod: second stage, first products
// p and the two saturation-scaled remainders, each an 8x8 product >> 8
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_prod
	import h2r_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	input  wire stage_ctl_t ctl,
	input  wire split_t     data_in,
	output logic            valid_s2,
	output prod_t           data_s2
);

	logic [2*ChanW-1:0] m_sr;
	logic [2*ChanW-1:0] m_sri;
	logic [2*ChanW-1:0] m_p;
	prod_t              nxt;

	always_comb begin
		m_sr  = data_in.sat * data_in.rem;
		m_sri = data_in.sat * (Full - data_in.rem);
		m_p   = data_in.val * data_in.nsat;
		nxt.region = data_in.region;
		nxt.sr     = m_sr[2*ChanW-1:ChanW];
		nxt.sri    = m_sri[2*ChanW-1:ChanW];
		nxt.p      = m_p[2*ChanW-1:ChanW];
		nxt.val    = data_in.val;
		nxt.grey   = data_in.grey;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.advance) begin
			valid_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance && ctl.valid) begin
			data_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

[design/h2r_mix.sv]
// ----------------------------------------------------------------------------
// h2r_mix: third stage, q and t products and channel routing
// forms q and t, cuts all terms to four bits and routes them by region
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_mix
	import h2r_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	input  wire stage_ctl_t ctl,
	input  wire prod_t      data_in,
	output logic            valid_s3,
	output rgb_t            data_s3
);

	logic [2*ChanW-1:0] m_q;
	logic [2*ChanW-1:0] m_t;
	logic [OutW-1:0]    v4;
	logic [OutW-1:0]    p4;
	logic [OutW-1:0]    q4;
	logic [OutW-1:0]    t4;
	rgb_t               nxt;

	always_comb begin
		m_q = data_in.val * (Full - data_in.sr);
		m_t = data_in.val * (Full - data_in.sri);
		v4  = data_in.val[ChanW-1:ChanW-OutW];
		p4  = data_in.p[ChanW-1:ChanW-OutW];
		q4  = m_q[2*ChanW-1:2*ChanW-OutW];
		t4  = m_t[2*ChanW-1:2*ChanW-OutW];
		if (data_in.grey) begin
			nxt = '{red: v4, green: v4, blue: v4};
		end else begin
			unique case (data_in.region)
				RGN_RED: nxt = '{red: v4, green: t4, blue: p4};
				RGN_YEL: nxt = '{red: q4, green: v4, blue: p4};
				RGN_GRN: nxt = '{red: p4, green: v4, blue: t4};
				RGN_CYN: nxt = '{red: p4, green: q4, blue: v4};
				RGN_BLU: nxt = '{red: t4, green: p4, blue: v4};
				default: nxt = '{red: v4, green: p4, blue: q4};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ctl.advance) begin
			valid_s3 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance && ctl.valid) begin
			data_s3 <= nxt;
		end
	end

endmodule

`default_nettype wire

[design/hsv_to_rgb444.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb444: integer hsv to 12-bit rgb colour converter
// three-stage pipeline turning one hsv triple into one rgb444 colour
// ----------------------------------------------------------------------------
// Converts each hsv beat (8-bit hue, saturation, brightness) into one rgb444
// beat. Throughput is one beat per clock while the output is not stalled.
// The pipeline has three register stages: region split, first products (p
// and the two scaled remainders) and second products (q and t) with channel
// routing, the last stage doubling as the output register. The first stage
// loads at the accepting edge, and the beat then passes through the second
// and third stage registers to the output. Each stage holds its beat only
// while the stage after it is full and stalled, so bubbles close up under
// back-pressure and the input keeps accepting while a result waits until
// every stage is full. A saturation of zero gives grey: the top four bits of
// brightness on all three channels. There is no configuration and no state
// beyond the pipeline.
`default_nettype none

module hsv_to_rgb444
	import h2r_pkg::*;
(
	input wire          clk,
	input wire          arst_n,
	h2r_hsv_if.sink     hsv,
	h2r_rgb_if.source   rgb
);

	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	split_t     data_s1;
	prod_t      data_s2;
	rgb_t       data_s3;
	stage_ctl_t ctl1;
	stage_ctl_t ctl2;
	stage_ctl_t ctl3;

	// a stage may load when it is empty or its beat moves on this cycle
	always_comb begin
		ctl3.advance = !valid_s3 || rgb.ready;
		ctl2.advance = !valid_s2 || ctl3.advance;
		ctl1.advance = !valid_s1 || ctl2.advance;
		ctl1.valid   = hsv.valid;
		ctl2.valid   = valid_s1;
		ctl3.valid   = valid_s2;
	end

	assign hsv.ready = ctl1.advance;

	// region and scaled remainder
	h2r_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl1),
		.hue        (hsv.hue),
		.saturation (hsv.saturation),
		.brightness (hsv.brightness),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	// p and the saturation-scaled remainders
	h2r_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl2),
		.data_in  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	// q, t and channel routing, output register
	h2r_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl3),
		.data_in  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	assign rgb.valid = valid_s3;
	assign rgb.red   = data_s3.red;
	assign rgb.green = data_s3.green;
	assign rgb.blue  = data_s3.blue;

endmodule

`default_nettype wire

[design/h2r_chk.sv]
// ----------------------------------------------------------------------------
// h2r_chk: port checker for the hsv to rgb444 converter
// watches both channels at the top level ports, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_chk
	import h2r_pkg::*;
(
	input wire            clk,
	input wire            arst_n,
	input wire            hsv_valid,
	input wire            hsv_ready,
	input wire            rgb_valid,
	input wire            rgb_ready,
	input wire [OutW-1:0] rgb_red,
	input wire [OutW-1:0] rgb_green,
	input wire [OutW-1:0] rgb_blue
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid)
		else $error("rgb beat dropped while stalled");

	// a stalled result keeps its colour
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> $stable(rgb_red) && $stable(rgb_green)
			&& $stable(rgb_blue))
		else $error("rgb beat changed while stalled");

	// an empty output stage means the pipeline cannot be blocking the input
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_valid |-> hsv_ready)
		else $error("input stalled with empty output stage");

	// a taken result frees room all the way back to the input
	a_drain_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_ready |-> hsv_ready)
		else $error("input stalled while output drains");

endmodule

bind hsv_to_rgb444 h2r_chk u_h2r_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.hsv_valid (hsv.valid),
	.hsv_ready (hsv.ready),
	.rgb_valid (rgb.valid),
	.rgb_ready (rgb.ready),
	.rgb_red   (rgb.red),
	.rgb_green (rgb.green),
	.rgb_blue  (rgb.blue)
);

`default_nettype wire
